[src/cctt_pkg.sv]
// ----------------------------------------------------------------------------
// Charset code table package
// Shared types, register indexes and field widths of the code table block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cctt_pkg;

  localparam int CODE_W  = 16;
  localparam int VALUE_W = 16;
  localparam int ROW_W   = 9;
  localparam int SIZE_W  = 9;
  localparam int COL_W   = 8;
  localparam int IDX_W   = 18;
  localparam int FIRST_W = 25;
  localparam int LEN_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COLS_PER_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLUMN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_SETTING = 2'd3;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_DEFINE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_DEFAULT = 9'd256;

  typedef struct packed {
    logic [ROW_W-1:0]   cols_per_row;
    logic [FIRST_W-1:0] first;
    logic [LEN_W-1:0]   len;
  } cctt_win_t;

endpackage

`default_nettype wire

[src/cctt_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address port shared by write and read, with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cctt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[src/cctt_cfg.sv]
// ----------------------------------------------------------------------------
// Code table configuration
// Register file for the table layout and the registered window bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cctt_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [cctt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cctt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output cctt_pkg::cctt_win_t                     win
);

  import cctt_pkg::*;

  logic [ROW_W-1:0]   cols_per_row_r;
  logic [CODE_W-1:0]  first_base_r;
  logic [COL_W-1:0]   first_column_r;
  logic [SIZE_W-1:0]  size_setting_r;
  logic [SIZE_W-1:0]  size_eff;
  cctt_win_t          win_r;
  cctt_win_t          win_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_per_row_r <= '0;
      first_base_r   <= '0;
      first_column_r <= '0;
      size_setting_r <= SIZE_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS_PER_ROW: cols_per_row_r <= cfg_wdata[ROW_W-1:0];
        REG_FIRST_BASE:   first_base_r   <= cfg_wdata[CODE_W-1:0];
        REG_FIRST_COLUMN: first_column_r <= cfg_wdata[COL_W-1:0];
        REG_SIZE_SETTING: size_setting_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    size_eff = (size_setting_r == '0) ? SIZE_DEFAULT : size_setting_r;
    win_nxt.cols_per_row = cols_per_row_r;
    if (cols_per_row_r != '0) begin
      win_nxt.first = FIRST_W'(cols_per_row_r) * FIRST_W'(first_base_r)
                    + FIRST_W'(first_column_r);
      win_nxt.len   = {size_eff, 8'd0};
    end else begin
      win_nxt.first = FIRST_W'(first_base_r);
      win_nxt.len   = LEN_W'(size_eff);
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  // The input stage indexes with the row width in the very cycle after a write.
  always_comb begin
    win              = win_r;
    win.cols_per_row = cols_per_row_r;
  end

endmodule

`default_nettype wire

[src/charset_code_to_unicode_table.sv]
// ----------------------------------------------------------------------------
// Charset code to Unicode table
// An accepted input word is held in the a, b and out registers in that order.
// Throughput: one word per cycle unless out_tready stalls; index, window
// check with table access, and output are each one register stage, with the
// single RAM port used at most once per word. Reset: configuration returns to
// flat layout, and all TABLE_DEPTH entries are zeroed while in_tready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module charset_code_to_unicode_table #(
  parameter int TABLE_DEPTH = 65536,
  parameter int CODE_LIMIT  = 65535
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [cctt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cctt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [31:0]                        in_tdata,  // code, target
  input  wire logic                               in_tuser,  // req_type
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [15:0]                        out_tdata, // unicode_value
  output logic                                    out_tuser  // accepted
);

  import cctt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [FIRST_W-1:0] DEPTH_W   = FIRST_W'(TABLE_DEPTH);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [CODE_W:0]    LIMIT_W   = (CODE_W + 1)'(CODE_LIMIT);

  cctt_win_t win;

  cctt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .win       (win)
  );

  logic            clr_r;
  logic [AW-1:0]   clr_addr_r;

  logic [CODE_W-1:0]  in_code;
  logic [COL_W-1:0]   in_col;
  logic [LEN_W-1:0]   in_prod;
  logic [IDX_W-1:0]   in_idx;
  logic               in_col_ok;

  logic               a_v_r, a_v_nxt;
  logic               a_req_r;
  logic [CODE_W-1:0]  a_code_r;
  logic [VALUE_W-1:0] a_target_r;
  logic               a_col_ok_r;
  logic [IDX_W-1:0]   a_idx_r;

  logic               b_v_r, b_v_nxt;
  logic               b_tbl_r;
  logic               b_acc_r;
  logic [VALUE_W-1:0] b_val_r;

  logic               out_v_r, out_v_nxt;
  logic [VALUE_W-1:0] out_val_r;
  logic               out_acc_r;

  logic out_free, b_free, a_free, a_adv, b_adv, in_acc;

  logic [FIRST_W-1:0] idx_w, off;
  logic               lo_ok, depth_ok, def_ok, lkp_tbl, code_ok;
  logic [VALUE_W-1:0] pass_val;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_addr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  // Handshake chain.
  assign out_free  = !out_v_r || out_tready;
  assign b_free    = !b_v_r || out_free;
  assign b_adv     = b_v_r && out_free;
  assign a_free    = !a_v_r || b_free;
  assign a_adv     = a_v_r && b_free;
  assign in_tready = a_free && !clr_r;
  assign in_acc    = in_tvalid && in_tready;

  // Flattened index of the incoming code.
  always_comb begin
    in_code   = in_tdata[CODE_W-1:0];
    in_col    = in_code[COL_W-1:0];
    in_prod   = LEN_W'(in_code[CODE_W-1:COL_W]) * LEN_W'(win.cols_per_row);
    in_col_ok = 1'b1;
    in_idx    = IDX_W'(in_code);
    if (win.cols_per_row != '0) begin
      in_col_ok = ROW_W'(in_col) < win.cols_per_row;
      in_idx    = IDX_W'(in_prod) + IDX_W'(in_col);
    end
  end

  // Window check and table access decision.
  always_comb begin
    idx_w    = FIRST_W'(a_idx_r);
    lo_ok    = idx_w >= win.first;
    off      = idx_w - win.first;
    depth_ok = off < DEPTH_W;
    def_ok   = (a_req_r == REQ_DEFINE) && ({1'b0, a_code_r} <= LIMIT_W) && a_col_ok_r
             && lo_ok && (a_idx_r < IDX_W'(win.len)) && depth_ok;
    code_ok  = ({1'b0, a_code_r} < LIMIT_W) && a_col_ok_r;
    lkp_tbl  = (a_req_r == REQ_LOOKUP) && code_ok && lo_ok
             && (off < FIRST_W'(win.len)) && depth_ok;
    pass_val = ((a_req_r == REQ_LOOKUP) && code_ok) ? a_code_r : '0;
  end

  always_comb begin
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_re    = 1'b0;
      ram_addr  = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = a_adv && def_ok;
      ram_re    = a_adv && lkp_tbl;
      ram_addr  = off[AW-1:0];
      ram_wdata = a_target_r;
    end
  end

  cctt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    a_v_nxt   = in_acc || (a_v_r && !b_free);
    b_v_nxt   = a_adv || (b_v_r && !out_free);
    out_v_nxt = b_adv || (out_v_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      a_v_r      <= 1'b0;
      b_v_r      <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          clr_r <= 1'b0;
        end
      end
      a_v_r   <= a_v_nxt;
      b_v_r   <= b_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_req_r    <= in_tuser;
      a_code_r   <= in_code;
      a_target_r <= in_tdata[CODE_W+VALUE_W-1:CODE_W];
      a_col_ok_r <= in_col_ok;
      a_idx_r    <= in_idx;
    end
    if (a_adv) begin
      b_tbl_r <= lkp_tbl;
      b_acc_r <= def_ok || lkp_tbl;
      b_val_r <= pass_val;
    end
    if (b_adv) begin
      out_val_r <= b_tbl_r ? ram_rdata : b_val_r;
      out_acc_r <= b_acc_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_acc_r;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr_r && in_tready))
    else $error("input accepted while the table is being cleared");

  a_single_port_use: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_read_lands_in_b: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (b_v_r && b_tbl_r && b_acc_r))
    else $error("table read without a matching lookup in the access stage");

  a_clear_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_r && clr_addr_r == LAST_ADDR) |=> !clr_r)
    else $error("clearing pass did not end at the last entry");
`endif

endmodule

`default_nettype wire

[test/code_table_checker.sv]
// ----------------------------------------------------------------------------
// Code table checker
// Watches the configuration port and both streams of the code table block,
// keeps its own copy of the registers and of the table, predicts the result
// of every accepted input word and compares each result word against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module code_table_checker #(
  parameter int unsigned TABLE_DEPTH = 65536,
  parameter int unsigned CODE_LIMIT  = 65535
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cctt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cctt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // code, target
  input  logic                            in_tuser,   // req_type
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [15:0]                     out_tdata,  // unicode_value
  input  logic                            out_tuser,  // accepted
  output int                              fail_count,
  output int                              pending_count
);

  import cctt_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               accepted;
  } code_result_t;

  logic [VALUE_W-1:0] code_table [TABLE_DEPTH];
  logic [ROW_W-1:0]   cols_per_row;
  logic [15:0]        first_base;
  logic [COL_W-1:0]   first_column;
  logic [SIZE_W-1:0]  size_setting;

  code_result_t expected_results [$];
  code_result_t oldest;
  int           mismatches = 0;

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t: mismatch: %s: got 0x%04h, expected 0x%04h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Works out the result of one word and applies a define to the table copy.
  function automatic code_result_t translate_word(input logic req,
                                                  input logic [15:0] code,
                                                  input logic [15:0] target);
    logic [31:0]  size_eff;
    logic [31:0]  win_len;
    logic [31:0]  win_first;
    logic [31:0]  idx;
    logic [31:0]  offset;
    logic         col_ok;
    code_result_t res;
    size_eff  = (size_setting == 0) ? 32'd256 : 32'(size_setting);
    win_len   = (cols_per_row == 0) ? size_eff : size_eff * 32'd256;
    win_first = (cols_per_row == 0) ? 32'(first_base)
                                    : 32'(cols_per_row) * 32'(first_base)
                                      + 32'(first_column);
    col_ok    = (cols_per_row == 0) || (32'(code[7:0]) < 32'(cols_per_row));
    idx       = (cols_per_row == 0) ? 32'(code)
                                    : 32'(code[15:8]) * 32'(cols_per_row) + 32'(code[7:0]);
    offset    = idx - win_first;
    res       = '0;
    if (req == REQ_DEFINE) begin
      if (32'(code) <= CODE_LIMIT && col_ok && idx >= win_first && idx < win_len
          && offset < TABLE_DEPTH) begin
        code_table[offset] = target;
        res.accepted = 1'b1;
      end
    end else if (32'(code) >= CODE_LIMIT || !col_ok) begin
      res = '0;
    end else if (idx >= win_first && offset < win_len && offset < TABLE_DEPTH) begin
      res.value    = code_table[offset];
      res.accepted = 1'b1;
    end else begin
      res.value = code;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cols_per_row = '0;
      first_base   = '0;
      first_column = '0;
      size_setting = SIZE_DEFAULT;
      for (int k = 0; k < TABLE_DEPTH; k++) code_table[k] = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COLS_PER_ROW: cols_per_row = cfg_wdata[ROW_W-1:0];
          REG_FIRST_BASE:   first_base   = cfg_wdata[15:0];
          REG_FIRST_COLUMN: first_column = cfg_wdata[COL_W-1:0];
          REG_SIZE_SETTING: size_setting = cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result word with nothing expected", out_tdata, 16'h0000);
        end else begin
          oldest = expected_results.pop_front();
          if (out_tdata !== oldest.value)
            flag_mismatch("unicode_value", out_tdata, oldest.value);
          if (out_tuser !== oldest.accepted)
            flag_mismatch("accepted", 16'(out_tuser), 16'(oldest.accepted));
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(translate_word(in_tuser, in_tdata[15:0],
                                                  in_tdata[31:16]));
    end
    pending_count <= expected_results.size();
    fail_count    <= mismatches;
  end

endmodule

[test/charset_code_to_unicode_table_tb.sv]
// ----------------------------------------------------------------------------
// Charset code to Unicode table testbench
// Drives defines and lookups through nine register settings (flat and row
// layouts, extreme values included) with random stalls on both streams in the
// first six settings, while a checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module charset_code_to_unicode_table_tb;
  import cctt_pkg::*;

  localparam int STALL_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 9;
  localparam int RANDOM_WORDS  = 215;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  out_tuser;
  int                    fail_count;
  int                    pending_count;

  int          send_idle   = 0;
  int          recv_idle   = 0;
  int          quiet_cycles = 0;
  int unsigned cur_rs, cur_fb, cur_fc, cur_size;
  logic [15:0] recent_codes [16];
  int          recent_ptr = 0;

  int unsigned rs_list   [PHASES] = '{0, 0,  94, 256, 1,     511, 0,     0, 128};
  int unsigned fb_list   [PHASES] = '{0, 32, 1,  0,   65535, 100, 65535, 0, 2};
  int unsigned fc_list   [PHASES] = '{0, 0,  1,  0,   255,   200, 0,     0, 255};
  int unsigned size_list [PHASES] = '{256, 200, 94, 0, 1,    511, 256,   1, 300};

  charset_code_to_unicode_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  code_table_checker table_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("charset_code_to_unicode_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic req, input logic [15:0] code,
                           input logic [15:0] target);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {target, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_setting(input int ph);
    cur_rs   = rs_list[ph];
    cur_fb   = fb_list[ph];
    cur_fc   = fc_list[ph];
    cur_size = size_list[ph];
    write_reg(REG_COLS_PER_ROW, cur_rs);
    write_reg(REG_FIRST_BASE, cur_fb);
    write_reg(REG_FIRST_COLUMN, cur_fc);
    write_reg(REG_SIZE_SETTING, cur_size);
    cfg_we <= 1'b0;
  endtask

  // Codes mostly land in and around the current window, with some noise.
  function automatic logic [15:0] pick_code();
    int unsigned roll, size_eff, span, rows, row, col;
    roll     = $urandom_range(99);
    size_eff = (cur_size == 0) ? 256 : cur_size;
    if (roll < 8) return 16'($urandom());
    if (roll < 10) return 16'hFFFF;
    if (cur_rs == 0) begin
      span = size_eff + 8;
      return 16'(cur_fb + $urandom_range(span) - 4);
    end
    rows = size_eff * 256 / cur_rs + 1;
    row  = cur_fb + $urandom_range(rows);
    col  = $urandom_range((cur_rs > 254) ? 255 : cur_rs + 1);
    return {row[7:0], col[7:0]};
  endfunction

  initial begin
    int          ph;
    int          i;
    logic        req;
    logic [15:0] code;
    logic [15:0] target;
    for (i = 0; i < 16; i++) recent_codes[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) drain_results();
      send_idle = (ph < 3) ? 34 : (ph < 6) ? 58 : 0;
      recv_idle = (ph < 3) ? 58 : (ph < 6) ? 34 : 0;
      apply_setting(ph);

      if (ph == 0) begin
        send_word(REQ_DEFINE, 16'h0000, 16'hFFFF);
        send_word(REQ_LOOKUP, 16'h0000, 16'h0000);
        send_word(REQ_DEFINE, 16'h00FF, 16'h1234);
        send_word(REQ_LOOKUP, 16'h00FF, 16'hFFFF);
        send_word(REQ_DEFINE, 16'h0100, 16'h4321);
        send_word(REQ_LOOKUP, 16'h0100, 16'h0000);
        send_word(REQ_LOOKUP, 16'hFFFF, 16'h0000);
        send_word(REQ_DEFINE, 16'hFFFF, 16'h5555);
        send_word(REQ_LOOKUP, 16'h0007, 16'h0000);
        send_word(REQ_DEFINE, 16'h0007, 16'h0000);
        send_word(REQ_LOOKUP, 16'h0007, 16'h0000);
        send_word(REQ_LOOKUP, 16'hFFFE, 16'h0000);
      end else if (ph == 2) begin
        send_word(REQ_DEFINE, 16'h0101, 16'hABCD);
        send_word(REQ_LOOKUP, 16'h0101, 16'h0000);
        send_word(REQ_DEFINE, 16'h015E, 16'h1111);
        send_word(REQ_LOOKUP, 16'h015E, 16'h0000);
        send_word(REQ_LOOKUP, 16'h0100, 16'h0000);
        send_word(REQ_DEFINE, 16'hFF5D, 16'h8000);
        send_word(REQ_LOOKUP, 16'hFF5D, 16'h0000);
        send_word(REQ_LOOKUP, 16'hFFFF, 16'h0000);
      end else if (ph == 5) begin
        // Row 230 lies past the end of the table once the first index is removed.
        send_word(REQ_DEFINE, 16'hE600, 16'h7777);
        send_word(REQ_LOOKUP, 16'hE600, 16'h0000);
        send_word(REQ_DEFINE, 16'h64C8, 16'h2468);
        send_word(REQ_LOOKUP, 16'h64C8, 16'h0000);
      end

      for (i = 0; i < RANDOM_WORDS; i++) begin
        if (ph == 1 && i == 100) drain_results();
        req = ($urandom_range(99) < 45) ? REQ_DEFINE : REQ_LOOKUP;
        if (req == REQ_LOOKUP && $urandom_range(99) < 55)
          code = recent_codes[$urandom_range(15)];
        else
          code = pick_code();
        target = ($urandom_range(99) < 5) ? 16'h0000 : 16'($urandom());
        if (req == REQ_DEFINE) begin
          recent_codes[recent_ptr] = code;
          recent_ptr = (recent_ptr + 1) % 16;
        end
        send_word(req, code, target);
      end
    end

    drain_results();
    if (fail_count == 0 && pending_count == 0) begin
      $display("charset_code_to_unicode_table test passed");
    end else begin
      $display("charset_code_to_unicode_table test failed");
    end
    $finish;
  end

endmodule
